/* rtl/core/lb64_pkg.sv */
package lb64_pkg;

  localparam int COUNT_BITS = 24;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_BADCHAR = 2'd2,
    KIND_BADLEN  = 2'd3
  } kind_t;

  // One decoded piece of work: up to three data bytes, then an optional status,
  // and an optional reset of the running byte count once it has been carried out.
  typedef struct packed {
    logic [1:0]      nbytes;
    logic [2:0][7:0] bytes;
    logic            has_status;
    kind_t           status;
    logic            clear;
  } cmd_t;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_VAL   = 6'd62;
  localparam logic [5:0] SLASH_VAL  = 6'd63;

  // Returns {invalid, value}.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
        d = ch - CH_UPPER_A;
        sextet_of = {1'b0, d[5:0]};
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
        d = ch - CH_LOWER_A;
        sextet_of = {1'b0, d[5:0] + LOWER_BASE};
      end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
        d = ch - CH_DIGIT_0;
        sextet_of = {1'b0, d[5:0] + DIGIT_BASE};
      end else if (ch == CH_PLUS) begin
        sextet_of = {1'b0, PLUS_VAL};
      end else if (ch == CH_SLASH) begin
        sextet_of = {1'b0, SLASH_VAL};
      end else begin
        sextet_of = 7'h40;
      end
    end
  endfunction

  function automatic logic is_skipped(input logic [7:0] ch);
    is_skipped = (ch == CH_EQUALS) || (ch == CH_CR) || (ch == CH_LF) ||
                 (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

endpackage

/* rtl/core/lb64_in_if.sv */
interface lb64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_message;

  modport source (output valid, output char_code, output end_of_message, input ready);
  modport sink (input valid, input char_code, input end_of_message, output ready);
endinterface

/* rtl/core/lb64_out_if.sv */
interface lb64_out_if;
  logic               valid;
  logic               ready;
  lb64_pkg::kind_t    kind;
  logic [7:0]         data_byte;
  logic [23:0]        byte_count;
  logic               last_of_run;

  modport source (output valid, output kind, output data_byte, output byte_count,
                  output last_of_run, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_count,
                input last_of_run, output ready);
endinterface

/* rtl/core/lb64_front.sv */
module lb64_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       char_code,
  input  logic             end_of_message,
  input  logic             fifo_full,
  output logic             push,
  output lb64_pkg::cmd_t   cmd
);

  logic [2:0][5:0] held;
  logic [2:0][5:0] held_next;
  logic [1:0]      held_count;
  logic [1:0]      held_count_next;
  logic            dropping;
  logic            dropping_next;
  logic            accept;
  logic            make_cmd;
  logic [6:0]      sx;

  assign in_ready = !fifo_full;
  assign accept = in_valid && in_ready;
  assign push = accept && make_cmd;
  assign sx = lb64_pkg::sextet_of(char_code);

  always_comb begin
    held_next = held;
    held_count_next = held_count;
    dropping_next = dropping;
    make_cmd = 1'b0;
    cmd.nbytes = 2'd0;
    cmd.bytes[0] = {held[0], held[1][5:4]};
    cmd.bytes[1] = {held[1][3:0], held[2][5:2]};
    cmd.bytes[2] = {held[2][1:0], sx[5:0]};
    cmd.has_status = 1'b0;
    cmd.status = lb64_pkg::KIND_OK;
    cmd.clear = 1'b0;
    if (accept) begin
      if (end_of_message) begin
        make_cmd = 1'b1;
        cmd.clear = 1'b1;
        held_next = '0;
        held_count_next = 2'd0;
        dropping_next = 1'b0;
        if (!dropping) begin
          cmd.has_status = 1'b1;
          if (held_count == 2'd1) begin
            cmd.status = lb64_pkg::KIND_BADLEN;
          end else if (held_count != 2'd0) begin
            cmd.nbytes = held_count - 2'd1;
          end
        end
      end else if (!dropping && !lb64_pkg::is_skipped(char_code)) begin
        if (sx[6]) begin
          make_cmd = 1'b1;
          cmd.has_status = 1'b1;
          cmd.status = lb64_pkg::KIND_BADCHAR;
          held_next = '0;
          held_count_next = 2'd0;
          dropping_next = 1'b1;
        end else if (held_count != 2'd3) begin
          held_next[held_count] = sx[5:0];
          held_count_next = held_count + 2'd1;
        end else begin
          make_cmd = 1'b1;
          cmd.nbytes = 2'd3;
          held_next = '0;
          held_count_next = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
    if (rst) begin
      held_count <= 2'd0;
      dropping <= 1'b0;
      held <= '0;
    end else begin
      held_count <= held_count_next;
      dropping <= dropping_next;
    end
  end

  a_drop_empty: assert property (@(posedge clk) disable iff (rst)
    dropping |-> held_count == 2'd0)
    else $error("front holds sextets while dropping");

endmodule

/* rtl/core/lb64_fifo.sv */
module lb64_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lb64_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lb64_pkg::cmd_t rd_data
);

  lb64_pkg::cmd_t                   entries [lb64_pkg::FIFO_DEPTH];
  logic [lb64_pkg::FIFO_PTR_BITS-1:0] wr_ptr;
  logic [lb64_pkg::FIFO_PTR_BITS-1:0] rd_ptr;
  logic [lb64_pkg::FIFO_PTR_BITS:0]   count;

  assign full = (count == (lb64_pkg::FIFO_PTR_BITS+1)'(lb64_pkg::FIFO_DEPTH));
  assign empty = (count == '0);
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("command queue read while empty");

endmodule

/* rtl/core/lb64_back.sv */
module lb64_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  lb64_pkg::cmd_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output lb64_pkg::kind_t out_kind,
  output logic [7:0]     out_data_byte,
  output logic [23:0]    out_byte_count,
  output logic           out_last
);

  logic [lb64_pkg::COUNT_BITS-1:0] total;
  logic [lb64_pkg::COUNT_BITS-1:0] total_inc;
  logic [1:0]                      sub;
  logic [2:0]                      nres;
  logic                            is_data;
  logic                            is_last;
  logic                            load;

  assign nres = {1'b0, head.nbytes} + {2'b00, head.has_status};
  assign is_data = (sub < head.nbytes);
  assign is_last = ({1'b0, sub} == nres - 3'd1);
  assign total_inc = (total == lb64_pkg::COUNT_MAX) ? total : total + 1'b1;
  assign load = head_valid && (nres != 3'd0) && (!out_valid || out_ready);
  // A command with no results only resets the count, so it leaves at once.
  assign pop = head_valid && ((nres == 3'd0) || (load && is_last));

  always_ff @(posedge clk) begin
    if (load) begin
      out_last <= is_last;
      if (is_data) begin
        out_kind <= lb64_pkg::KIND_DATA;
        out_data_byte <= head.bytes[sub];
        out_byte_count <= 24'(total_inc);
      end else begin
        out_kind <= head.status;
        out_data_byte <= 8'd0;
        out_byte_count <= 24'(total);
      end
    end
    if (rst) begin
      out_valid <= 1'b0;
      sub <= 2'd0;
      total <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        sub <= 2'd0;
      end else if (load) begin
        sub <= sub + 2'd1;
      end
      if (pop && head.clear) begin
        total <= '0;
      end else if (load && is_data) begin
        total <= total_inc;
      end
    end
  end

  a_sub_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid && nres != 3'd0 |-> {1'b0, sub} < nres)
    else $error("result index past the end of its command");

  a_clear_count: assert property (@(posedge clk) disable iff (rst)
    pop && head.clear |=> total == '0)
    else $error("byte count not reset at end of message");

endmodule

/* rtl/core/lenient_base64_decoder_top.sv */
// Path: the command queue is written at the edge that accepts the character beat that
// completes a result; the output register is loaded from the queue head when it is free.
// Throughput: one character or terminator per cycle unless the command queue is full;
// the back end issues one result per cycle unless the output stalls.
// Reset: synchronous, active high; clears the held values, the byte count, the
// dropping flag, the command queue and the output valid.
module lenient_base64_decoder_top (
  input logic        clk,
  input logic        rst,
  lb64_in_if.sink    char_in,
  lb64_out_if.source result_out
);

  lb64_pkg::cmd_t push_cmd;
  lb64_pkg::cmd_t head_cmd;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  lb64_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (char_in.valid),
    .in_ready       (char_in.ready),
    .char_code      (char_in.char_code),
    .end_of_message (char_in.end_of_message),
    .fifo_full      (full),
    .push           (push),
    .cmd            (push_cmd)
  );

  lb64_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_cmd),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (head_cmd)
  );

  lb64_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (!empty),
    .head           (head_cmd),
    .pop            (pop),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .out_kind       (result_out.kind),
    .out_data_byte  (result_out.data_byte),
    .out_byte_count (result_out.byte_count),
    .out_last       (result_out.last_of_run)
  );

endmodule
